// ===== sv/adtc_pkg.sv =====
// Shared types, constants and codes for the drive/tone/crush/delay chain.
`timescale 1ns / 1ps
package adtc_pkg;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned WideW    = 20;
  localparam int unsigned StW      = 25;
  localparam int unsigned MulAw    = 26;
  localparam int unsigned MulBw    = 17;
  localparam int unsigned ProdW    = MulAw + MulBw;
  localparam int unsigned DlyDepth = 16384;
  localparam int unsigned DlyAw    = $clog2(DlyDepth);
  localparam int unsigned CfgIw    = 3;
  localparam int unsigned CfgDw    = 14;
  localparam int unsigned Knee     = 18000;
  localparam int unsigned FbCap    = 244;
  localparam int unsigned ToneOff  = 255;
  // floor(v/3) == (v * Div3Mul) >> Div3Shift for all 16-bit v
  localparam int unsigned Div3Mul   = 43691;
  localparam int unsigned Div3Shift = 17;
  localparam int unsigned Div3QW    = 15;

  typedef enum logic [CfgIw-1:0] {
    CFG_BYPASS,
    CFG_DRIVE,
    CFG_TONE,
    CFG_CRUSH,
    CFG_TAPS,
    CFG_FB,
    CFG_MIX,
    CFG_FREEZE
  } cfg_idx_e;

  typedef struct packed {
    logic             bypass;
    logic [7:0]       drive;
    logic [7:0]       tone;
    logic [7:0]       crush;
    logic [CfgDw-1:0] taps;
    logic [7:0]       fb;
    logic [7:0]       mix;
    logic             freeze;
  } cfg_t;

  typedef struct packed {
    logic bypass;
    logic drive_en;
    logic tone_en;
    logic crush_en;
    logic dly_en;
    logic freeze;
  } cfg_flags_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_DRV_MUL,
    OP_DRV_SHF,
    OP_SAT_MUL,
    OP_SAT_FIN,
    OP_TONE_MUL,
    OP_TONE_UPD,
    OP_CRUSH,
    OP_RD,
    OP_WET,
    OP_FB_MUL,
    OP_MIX_MUL,
    OP_ADD_DRY,
    OP_WR
  } op_e;

  typedef struct packed {
    op_e  op;
    logic out_load;
  } dp_cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DRV_MUL,
    ST_DRV_SHF,
    ST_DSAT_MUL,
    ST_DSAT_FIN,
    ST_TONE_MUL,
    ST_TONE_UPD,
    ST_CRUSH,
    ST_RD,
    ST_WET,
    ST_FB_MUL,
    ST_FB_ADD,
    ST_FSAT_MUL,
    ST_FSAT_FIN,
    ST_WR,
    ST_MIX_MUL,
    ST_MIX_ADD,
    ST_OSAT_MUL,
    ST_OSAT_FIN,
    ST_DONE
  } state_e;

endpackage

// ===== sv/adtc_cfg_regs.sv =====
// Configuration register bank with stage enable decode.
`timescale 1ns / 1ps
module adtc_cfg_regs import adtc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CfgIw-1:0] cfg_index_i,
  input  logic [CfgDw-1:0] cfg_data_i,
  output cfg_t             cfg_o,
  output cfg_flags_t       flags_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bypass <= 1'b0;
      cfg_q.drive  <= '0;
      cfg_q.tone   <= 8'(ToneOff);
      cfg_q.crush  <= '0;
      cfg_q.taps   <= CfgDw'(1);
      cfg_q.fb     <= '0;
      cfg_q.mix    <= '0;
      cfg_q.freeze <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_BYPASS: cfg_q.bypass <= cfg_data_i[0];
        CFG_DRIVE:  cfg_q.drive  <= cfg_data_i[7:0];
        CFG_TONE:   cfg_q.tone   <= cfg_data_i[7:0];
        CFG_CRUSH:  cfg_q.crush  <= cfg_data_i[7:0];
        CFG_TAPS:   cfg_q.taps   <= cfg_data_i;
        CFG_FB:     cfg_q.fb     <= cfg_data_i[7:0];
        CFG_MIX:    cfg_q.mix    <= cfg_data_i[7:0];
        CFG_FREEZE: cfg_q.freeze <= cfg_data_i[0];
      endcase
    end
  end

  assign cfg_o            = cfg_q;
  assign flags_o.bypass   = cfg_q.bypass;
  assign flags_o.drive_en = cfg_q.drive != '0;
  assign flags_o.tone_en  = cfg_q.tone != 8'(ToneOff);
  assign flags_o.crush_en = cfg_q.crush != '0;
  assign flags_o.dly_en   = (cfg_q.mix != '0) | cfg_q.freeze;
  assign flags_o.freeze   = cfg_q.freeze;

endmodule

// ===== sv/adtc_ctrl.sv =====
// Sequencer: steps one sample through the enabled stages, owns the handshakes.
`timescale 1ns / 1ps
module adtc_ctrl import adtc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_flags_t flags_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  state_e after_crush, after_tone, after_drive, first_st;

  always_comb begin
    after_crush = flags_i.dly_en ? ST_RD : ST_DONE;
    after_tone  = flags_i.crush_en ? ST_CRUSH : after_crush;
    after_drive = flags_i.tone_en ? ST_TONE_MUL : after_tone;
    priority if (flags_i.bypass) begin
      first_st = ST_DONE;
    end else if (flags_i.drive_en) begin
      first_st = ST_DRV_MUL;
    end else begin
      first_st = after_drive;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = first_st;
      ST_DRV_MUL:  state_d = ST_DRV_SHF;
      ST_DRV_SHF:  state_d = ST_DSAT_MUL;
      ST_DSAT_MUL: state_d = ST_DSAT_FIN;
      ST_DSAT_FIN: state_d = after_drive;
      ST_TONE_MUL: state_d = ST_TONE_UPD;
      ST_TONE_UPD: state_d = after_tone;
      ST_CRUSH:    state_d = after_crush;
      ST_RD:       state_d = ST_WET;
      ST_WET:      state_d = flags_i.freeze ? ST_WR : ST_FB_MUL;
      ST_FB_MUL:   state_d = ST_FB_ADD;
      ST_FB_ADD:   state_d = ST_FSAT_MUL;
      ST_FSAT_MUL: state_d = ST_FSAT_FIN;
      ST_FSAT_FIN: state_d = ST_WR;
      ST_WR:       state_d = ST_MIX_MUL;
      ST_MIX_MUL:  state_d = ST_MIX_ADD;
      ST_MIX_ADD:  state_d = ST_OSAT_MUL;
      ST_OSAT_MUL: state_d = ST_OSAT_FIN;
      ST_OSAT_FIN: state_d = ST_DONE;
      ST_DONE:     if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op       = OP_IDLE;
    cmd_o.out_load = 1'b0;
    unique case (state_q)
      ST_IDLE:     if (in_valid_i) cmd_o.op = OP_LOAD;
      ST_DRV_MUL:  cmd_o.op = OP_DRV_MUL;
      ST_DRV_SHF:  cmd_o.op = OP_DRV_SHF;
      ST_DSAT_MUL,
      ST_FSAT_MUL,
      ST_OSAT_MUL: cmd_o.op = OP_SAT_MUL;
      ST_DSAT_FIN,
      ST_FSAT_FIN,
      ST_OSAT_FIN: cmd_o.op = OP_SAT_FIN;
      ST_TONE_MUL: cmd_o.op = OP_TONE_MUL;
      ST_TONE_UPD: cmd_o.op = OP_TONE_UPD;
      ST_CRUSH:    cmd_o.op = OP_CRUSH;
      ST_RD:       cmd_o.op = OP_RD;
      ST_WET:      cmd_o.op = OP_WET;
      ST_FB_MUL:   cmd_o.op = OP_FB_MUL;
      ST_MIX_MUL:  cmd_o.op = OP_MIX_MUL;
      ST_FB_ADD,
      ST_MIX_ADD:  cmd_o.op = OP_ADD_DRY;
      ST_WR:       cmd_o.op = OP_WR;
      ST_DONE:     cmd_o.out_load = !out_valid_q || out_ready_i;
      default:     cmd_o.op = OP_IDLE;
    endcase
    out_valid_d = cmd_o.out_load | (out_valid_q & ~out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/adtc_dpath.sv =====
// Datapath: shared multiplier, saturator, filter/hold state, delay memory, beat register.
`timescale 1ns / 1ps
module adtc_dpath import adtc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  dp_cmd_t            cmd_i,
  input  logic [SampleW-1:0] sample_i,
  output logic [SampleW-1:0] sample_o
);

  logic signed [WideW-1:0]   x_q;
  logic signed [SampleW-1:0] dry_q, wet_q, hold_q, rdata_q;
  logic signed [ProdW-1:0]   p_q;
  logic signed [StW-1:0]     st_q;
  logic [7:0]                hcnt_q;
  logic [DlyAw-1:0]          wp_q;
  logic                      wrap_q, rd_valid_q;
  logic [SampleW-1:0]        out_q;
  logic [SampleW-1:0]        mem [DlyDepth];

  // shared multiplier
  logic signed [MulAw-1:0] mul_a;
  logic signed [MulBw-1:0] mul_b;
  logic signed [ProdW-1:0] prod;
  logic                    mul_en;
  logic [11:0]             gain;
  logic [7:0]              tone_c, fb_c;
  logic signed [MulAw-1:0] tone_diff;

  // saturator on x_q
  logic signed [WideW:0]   sx, sat_pre;
  logic [WideW:0]          mag, excess;
  logic                    over;
  logic [SampleW-1:0]      sat_v;
  logic [Div3QW-1:0]       q3;
  logic [SampleW:0]        sat_mag;
  logic [SampleW-1:0]      sat_res;

  logic signed [StW-1:0]   st_new;
  logic signed [SampleW-1:0] p_sh;
  logic [DlyAw-1:0]        tap_c, raddr;

  always_comb begin
    gain      = 12'd256 + {1'b0, cfg_i.drive, 3'b000};
    tone_c    = (cfg_i.tone == '0) ? 8'd1 : cfg_i.tone;
    fb_c      = (cfg_i.fb > 8'(FbCap)) ? 8'(FbCap) : cfg_i.fb;
    tone_diff = $signed({{2{x_q[SampleW-1]}}, x_q[SampleW-1:0], 8'b0})
              - $signed({st_q[StW-1], st_q});
    mul_en    = 1'b1;
    unique case (cmd_i.op)
      OP_DRV_MUL: begin
        mul_a = {{(MulAw-WideW){x_q[WideW-1]}}, x_q};
        mul_b = $signed({5'b0, gain});
      end
      OP_SAT_MUL: begin
        mul_a = $signed({10'b0, sat_v});
        mul_b = $signed(MulBw'(Div3Mul));
      end
      OP_TONE_MUL: begin
        mul_a = tone_diff;
        mul_b = $signed({9'b0, tone_c});
      end
      OP_FB_MUL: begin
        mul_a = {{(MulAw-SampleW){wet_q[SampleW-1]}}, wet_q};
        mul_b = $signed({9'b0, fb_c});
      end
      OP_MIX_MUL: begin
        mul_a = {{(MulAw-SampleW){wet_q[SampleW-1]}}, wet_q};
        mul_b = $signed({9'b0, cfg_i.mix});
      end
      default: begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b0;
      end
    endcase
    prod = mul_a * mul_b;
  end

  // three-segment saturator, split round the multiplier: excess in, quotient back
  always_comb begin
    sx      = {x_q[WideW-1], x_q};
    mag     = x_q[WideW-1] ? unsigned'(-sx) : unsigned'(sx);
    over    = mag > (WideW+1)'(Knee);
    excess  = mag - (WideW+1)'(Knee);
    sat_v   = (excess > (WideW+1)'(16'hFFFF)) ? 16'hFFFF : excess[SampleW-1:0];
    q3      = p_q[Div3Shift +: Div3QW];
    sat_mag = (SampleW+1)'(Knee) + {2'b0, q3};
    if (!over) begin
      sat_pre = sx;
    end else if (x_q[WideW-1]) begin
      sat_pre = -$signed({4'b0, sat_mag});
    end else begin
      sat_pre = $signed({4'b0, sat_mag});
    end
    priority if (sat_pre > 21'sd32767) begin
      sat_res = 16'h7FFF;
    end else if (sat_pre < -21'sd32768) begin
      sat_res = 16'h8000;
    end else begin
      sat_res = sat_pre[SampleW-1:0];
    end
  end

  always_comb begin
    st_new = st_q + p_q[StW+7:8];
    p_sh   = p_q[SampleW+7:8];
    priority if (cfg_i.taps == '0) begin
      tap_c = DlyAw'(1);
    end else if (32'(cfg_i.taps) > DlyDepth - 1) begin
      tap_c = DlyAw'(DlyDepth - 1);
    end else begin
      tap_c = DlyAw'(cfg_i.taps);
    end
    if (wp_q >= tap_c) begin
      raddr = wp_q - tap_c;
    end else begin
      raddr = DlyAw'(32'(wp_q) + DlyDepth - 32'(tap_c));
    end
  end

  // delay memory; entries below the fill point (or all, once wrapped) are written
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_WR) begin
      mem[wp_q] <= cfg_i.freeze ? wet_q : x_q[SampleW-1:0];
    end
    if (cmd_i.op == OP_RD) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) p_q <= prod;
    if (cmd_i.out_load) out_q <= x_q[SampleW-1:0];
    unique case (cmd_i.op)
      OP_LOAD:    x_q <= {{(WideW-SampleW){sample_i[SampleW-1]}}, sample_i};
      OP_DRV_SHF: x_q <= p_q[WideW+7:8];
      OP_SAT_FIN: x_q <= {{(WideW-SampleW){sat_res[SampleW-1]}}, sat_res};
      OP_TONE_UPD: x_q <= {{(WideW-StW+8){st_new[StW-1]}}, st_new[StW-1:8]};
      OP_CRUSH: begin
        if (hcnt_q <= 8'd1) begin
          hold_q <= x_q[SampleW-1:0];
        end else begin
          x_q <= {{(WideW-SampleW){hold_q[SampleW-1]}}, hold_q};
        end
      end
      OP_RD:      dry_q <= x_q[SampleW-1:0];
      OP_WET:     wet_q <= rd_valid_q ? rdata_q : '0;
      OP_ADD_DRY: x_q <= {{(WideW-SampleW){dry_q[SampleW-1]}}, dry_q}
                       + {{(WideW-SampleW){p_sh[SampleW-1]}}, p_sh};
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= '0;
      hcnt_q     <= '0;
      wp_q       <= '0;
      wrap_q     <= 1'b0;
      rd_valid_q <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        OP_TONE_UPD: st_q <= st_new;
        OP_CRUSH: begin
          if (hcnt_q <= 8'd1) begin
            hcnt_q <= 8'(cfg_i.crush[7:2]) + 8'd1;
          end else begin
            hcnt_q <= hcnt_q - 8'd1;
          end
        end
        OP_RD: rd_valid_q <= wrap_q | (raddr < wp_q);
        OP_WR: begin
          if (32'(wp_q) == DlyDepth - 1) begin
            wp_q   <= '0;
            wrap_q <= 1'b1;
          end else begin
            wp_q <= wp_q + DlyAw'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign sample_o = out_q;

endmodule

// ===== sv/audio_drive_tone_crush_delay_chain.sv =====
// Top level of the drive, tone, crush and feedback delay chain.
// One signed 16-bit sample in, one processed sample out, one sample at a time.
// With bypass set, a sample goes from accept straight to hand-off; with every
// stage on it passes drive, tone, crush and delay (a shorter delay path under
// freeze) in turn; the single shared multiplier, each use followed by a
// register, and the one-port delay memory set the pace. A new sample is taken
// once the previous result is in the output register. Configuration is to be
// written only while idle; the block itself does not enforce it. The delay
// memory needs no clearing pass; a fill pointer marks the written entries.
`timescale 1ns / 1ps
module audio_drive_tone_crush_delay_chain import adtc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIw-1:0]   cfg_index_i,
  input  logic [CfgDw-1:0]   cfg_data_i,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [SampleW-1:0] s_axis_tdata_i,  // [15:0] sample_in
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [SampleW-1:0] m_axis_tdata_o   // [15:0] sample_out
);

  cfg_t       cfg;
  cfg_flags_t flags;
  dp_cmd_t    cmd;

  adtc_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .cfg_o   (cfg),
    .flags_o (flags)
  );

  adtc_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .flags_i     (flags),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  adtc_dpath u_dpath (
    .clk_i,
    .rst_ni,
    .cfg_i    (cfg),
    .cmd_i    (cmd),
    .sample_i (s_axis_tdata_i),
    .sample_o (m_axis_tdata_o)
  );

endmodule

// ===== sv/adtc_checker.sv =====
// Port-level checks for the effect chain, bound to the top level.
`timescale 1ns / 1ps
module adtc_checker import adtc_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid_i,
  input logic               s_axis_tready_o,
  input logic               m_axis_tvalid_o,
  input logic               m_axis_tready_i,
  input logic [SampleW-1:0] m_axis_tdata_o
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result beat dropped or changed while stalled");

  // one sample at a time: busy right after an accepted beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while a sample is in flight");

  // no result appears in the cycle straight after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !$rose(m_axis_tvalid_o))
    else $error("result raised too early");

  // a new result is only produced out of a busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(s_axis_tready_o))
    else $error("result raised while idle");

endmodule

bind audio_drive_tone_crush_delay_chain adtc_checker u_adtc_checker (.*);

// ===== tb/tb_audio_drive_tone_crush_delay_chain.sv =====
// Self-checking testbench for the drive, tone, crush and feedback delay chain.
`timescale 1ns / 1ps
module tb_audio_drive_tone_crush_delay_chain;
  import adtc_pkg::*;

  localparam int     Depth      = DlyDepth;
  localparam longint KneeL      = Knee;
  localparam longint FbCapL     = FbCap;
  localparam longint ToneOffL   = ToneOff;
  localparam int     CycleLimit = 400000;
  localparam int     RandItems  = 1900;
  localparam logic   ROW_SMP    = 1'b0;
  localparam logic   ROW_CFG    = 1'b1;
  localparam logic   PRD        = 1'b0;
  localparam logic   CHK        = 1'b1;

  typedef struct packed {
    logic        kind;
    cfg_idx_e    idx;
    logic [15:0] val;    // sample, or register value
    logic        known;
    logic [15:0] want;
  } dir_row_t;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               cfg_we_i        = 1'b0;
  logic [CfgIw-1:0]   cfg_index_i     = '0;
  logic [CfgDw-1:0]   cfg_data_i      = '0;
  logic               s_axis_tvalid_i = 1'b0;
  logic               s_axis_tready_o;
  logic [SampleW-1:0] s_axis_tdata_i  = '0;
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  logic [SampleW-1:0] m_axis_tdata_o;

  audio_drive_tone_crush_delay_chain dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #4 clk_i = ~clk_i;

  // register shadow
  longint sh_bypass = 0;
  longint sh_drive  = 0;
  longint sh_tone   = 255;
  longint sh_crush  = 0;
  longint sh_taps   = 1;
  longint sh_fb     = 0;
  longint sh_mix    = 0;
  longint sh_freeze = 0;

  // effect state
  longint            tone_acc  = 0;
  longint            held_smp  = 0;
  longint            hold_left = 0;
  int                wr_ptr    = 0;
  logic signed [15:0] echo_mem [Depth] = '{default: '0};

  logic [15:0] want_samples [$];
  logic [15:0] head_want;
  int          bad_count   = 0;
  int          cycle_count = 0;
  bit          steady      = 1'b0;

  dir_row_t dir_rows [49] = '{
    '{ROW_SMP, CFG_BYPASS, 16'h0000, CHK, 16'h0000},
    '{ROW_SMP, CFG_BYPASS, 16'h7FFF, CHK, 16'h7FFF},
    '{ROW_SMP, CFG_BYPASS, 16'h8000, CHK, 16'h8000},
    '{ROW_SMP, CFG_BYPASS, 16'h0001, CHK, 16'h0001},
    '{ROW_SMP, CFG_BYPASS, 16'hFFFF, CHK, 16'hFFFF},
    '{ROW_SMP, CFG_BYPASS, 16'hA5A5, CHK, 16'hA5A5},
    '{ROW_SMP, CFG_BYPASS, 16'h5A5A, CHK, 16'h5A5A},
    '{ROW_CFG, CFG_BYPASS, 16'h0001, PRD, 16'h0000},
    '{ROW_CFG, CFG_DRIVE,  16'h00FF, PRD, 16'h0000},
    '{ROW_CFG, CFG_MIX,    16'h00FF, PRD, 16'h0000},
    '{ROW_SMP, CFG_BYPASS, 16'h1234, CHK, 16'h1234},
    '{ROW_SMP, CFG_BYPASS, 16'h8000, CHK, 16'h8000},
    '{ROW_CFG, CFG_BYPASS, 16'h0000, PRD, 16'h0000},
    '{ROW_CFG, CFG_MIX,    16'h0000, PRD, 16'h0000},
    '{ROW_SMP, CFG_BYPASS, 16'h7FFF, CHK, 16'h7FFF},
    '{ROW_SMP, CFG_BYPASS, 16'h8000, CHK, 16'h8000},
    '{ROW_CFG, CFG_DRIVE,  16'h0001, PRD, 16'h0000},
    '{ROW_SMP, CFG_BYPASS, 16'h4650, PRD, 16'h0000},
    '{ROW_SMP, CFG_BYPASS, 16'hB9B0, PRD, 16'h0000},
    '{ROW_CFG, CFG_DRIVE,  16'h0000, PRD, 16'h0000},
    '{ROW_CFG, CFG_TONE,   16'h0000, PRD, 16'h0000},
    '{ROW_SMP, CFG_BYPASS, 16'h7FFF, PRD, 16'h0000},
    '{ROW_SMP, CFG_BYPASS, 16'h7FFF, PRD, 16'h0000},
    '{ROW_CFG, CFG_TONE,   16'h00FE, PRD, 16'h0000},
    '{ROW_SMP, CFG_BYPASS, 16'h8000, PRD, 16'h0000},
    '{ROW_CFG, CFG_TONE,   16'h00FF, PRD, 16'h0000},
    '{ROW_CFG, CFG_CRUSH,  16'h00FF, PRD, 16'h0000},
    '{ROW_SMP, CFG_BYPASS, 16'h1111, PRD, 16'h0000},
    '{ROW_SMP, CFG_BYPASS, 16'h2222, PRD, 16'h0000},
    '{ROW_CFG, CFG_CRUSH,  16'h0001, PRD, 16'h0000},
    '{ROW_SMP, CFG_BYPASS, 16'h3333, PRD, 16'h0000},
    '{ROW_CFG, CFG_CRUSH,  16'h0000, PRD, 16'h0000},
    '{ROW_CFG, CFG_TAPS,   16'h0000, PRD, 16'h0000},
    '{ROW_CFG, CFG_FB,     16'h00FF, PRD, 16'h0000},
    '{ROW_CFG, CFG_MIX,    16'h00FF, PRD, 16'h0000},
    '{ROW_SMP, CFG_BYPASS, 16'h7FFF, PRD, 16'h0000},
    '{ROW_SMP, CFG_BYPASS, 16'h7FFF, PRD, 16'h0000},
    '{ROW_SMP, CFG_BYPASS, 16'h8000, PRD, 16'h0000},
    '{ROW_CFG, CFG_FREEZE, 16'h0001, PRD, 16'h0000},
    '{ROW_CFG, CFG_MIX,    16'h0000, PRD, 16'h0000},
    '{ROW_SMP, CFG_BYPASS, 16'h4000, PRD, 16'h0000},
    '{ROW_SMP, CFG_BYPASS, 16'h4000, PRD, 16'h0000},
    '{ROW_CFG, CFG_TAPS,   16'h3FFF, PRD, 16'h0000},
    '{ROW_CFG, CFG_FREEZE, 16'h0000, PRD, 16'h0000},
    '{ROW_CFG, CFG_MIX,    16'h0080, PRD, 16'h0000},
    '{ROW_SMP, CFG_BYPASS, 16'h1000, PRD, 16'h0000},
    '{ROW_CFG, CFG_MIX,    16'h0000, PRD, 16'h0000},
    '{ROW_CFG, CFG_FB,     16'h0000, PRD, 16'h0000},
    '{ROW_CFG, CFG_TAPS,   16'h0001, PRD, 16'h0000}
  };

  // 3:1 above the knee, truncating, then clip to 16 bits
  function automatic longint knee_clip(longint v);
    if (v > KneeL) v = KneeL + (v - KneeL) / 3;
    else if (v < -KneeL) v = -KneeL + (v + KneeL) / 3;
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return v;
  endfunction

  function automatic logic [15:0] chain_predict(logic [15:0] raw);
    longint x;
    longint c;
    longint wet;
    longint fb;
    int     tap;
    int     rd;
    x = longint'($signed(raw));
    if (sh_bypass == 0) begin
      if (sh_drive != 0) x = knee_clip((x * (256 + 8 * sh_drive)) >>> 8);
      if (sh_tone < ToneOffL) begin
        c = (sh_tone < 1) ? 1 : sh_tone;
        tone_acc += ((x * 256 - tone_acc) * c) >>> 8;
        x = tone_acc >>> 8;
      end
      if (sh_crush != 0) begin
        if (hold_left <= 1) begin
          hold_left = 1 + sh_crush / 4;
          held_smp  = x;
        end else begin
          hold_left--;
        end
        x = held_smp;
      end
      if (sh_mix != 0 || sh_freeze != 0) begin
        tap = int'(sh_taps);
        if (tap < 1) tap = 1;
        if (tap > Depth - 1) tap = Depth - 1;
        rd  = (wr_ptr + Depth - tap) % Depth;
        wet = echo_mem[rd];
        fb  = (sh_fb > FbCapL) ? FbCapL : sh_fb;
        echo_mem[wr_ptr] = 16'(sh_freeze != 0 ? wet : knee_clip(x + ((wet * fb) >>> 8)));
        wr_ptr = (wr_ptr + 1) % Depth;
        x = knee_clip(x + ((wet * sh_mix) >>> 8));
      end
    end
    return 16'(x);
  endfunction

  function automatic int pick_byte();
    case ($urandom_range(3))
      0:       return 0;
      1:       return 255;
      default: return $urandom_range(255);
    endcase
  endfunction

  task automatic cfg_write(cfg_idx_e idx, int val);
    s_axis_tvalid_i <= 1'b0;
    while (want_samples.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[CfgDw-1:0];
    case (idx)
      CFG_BYPASS: sh_bypass = val & 1;
      CFG_DRIVE:  sh_drive  = val & 8'hFF;
      CFG_TONE:   sh_tone   = val & 8'hFF;
      CFG_CRUSH:  sh_crush  = val & 8'hFF;
      CFG_TAPS:   sh_taps   = val & 14'h3FFF;
      CFG_FB:     sh_fb     = val & 8'hFF;
      CFG_MIX:    sh_mix    = val & 8'hFF;
      CFG_FREEZE: sh_freeze = val & 1;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // valid stays up after the beat; the next call or the caller lowers it
  task automatic feed_sample(logic [15:0] s, logic known, logic [15:0] typed);
    logic [15:0] pred;
    cfg_we_i <= 1'b0;
    while (!steady && $urandom_range(99) < 12) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= s;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pred = chain_predict(s);
    want_samples.push_back(known ? typed : pred);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready_i <= steady || ($urandom_range(99) >= 12);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (want_samples.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got %h", $time, m_axis_tdata_o);
          bad_count++;
        end else begin
          head_want = want_samples.pop_front();
          if (m_axis_tdata_o !== head_want) begin
            $display("%0t: sample_out expected %h, got %h", $time, head_want,
                     m_axis_tdata_o);
            bad_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_audio_drive_tone_crush_delay_chain: FAIL");
      $finish;
    end
  end

  initial begin
    dir_row_t    r;
    int          fed;
    int          phase;
    int          len;
    int          v;
    logic [15:0] s;
    fed   = 0;
    phase = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.kind == ROW_CFG) cfg_write(r.idx, int'(r.val));
      else feed_sample(r.val, r.known, r.want);
    end

    while (fed < RandItems) begin
      cfg_write(CFG_BYPASS, ($urandom_range(9) == 0) ? 1 : 0);
      cfg_write(CFG_DRIVE, pick_byte());
      case ($urandom_range(3))
        0:       v = 255;
        1:       v = 0;
        2:       v = 254;
        default: v = $urandom_range(255);
      endcase
      cfg_write(CFG_TONE, v);
      case ($urandom_range(3))
        0:       v = 0;
        1:       v = 255;
        2:       v = $urandom_range(7, 1);
        default: v = $urandom_range(255);
      endcase
      cfg_write(CFG_CRUSH, v);
      case ($urandom_range(3))
        0:       v = 0;
        1:       v = 16383;
        2:       v = $urandom_range(8, 1);
        default: v = $urandom_range(300, 1);
      endcase
      cfg_write(CFG_TAPS, v);
      cfg_write(CFG_FB, pick_byte());
      cfg_write(CFG_MIX, pick_byte());
      cfg_write(CFG_FREEZE, ($urandom_range(4) == 0) ? 1 : 0);

      steady = (phase == 3);
      len = $urandom_range(220, 80);
      for (int k = 0; k < len; k++) begin
        case ($urandom_range(9))
          0:       s = 16'h7FFF;
          1:       s = 16'h8000;
          2:       s = 16'($urandom_range(600)) - 16'd300;
          default: s = 16'($urandom);
        endcase
        feed_sample(s, PRD, '0);
      end
      steady = 1'b0;
      fed += len;
      phase++;
    end

    s_axis_tvalid_i <= 1'b0;
    cfg_we_i        <= 1'b0;
    while (want_samples.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (bad_count == 0) begin
      $display("tb_audio_drive_tone_crush_delay_chain: PASS");
    end else begin
      $display("tb_audio_drive_tone_crush_delay_chain: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/adtc_pkg.sv
sv/adtc_cfg_regs.sv
sv/adtc_ctrl.sv
sv/adtc_dpath.sv
sv/audio_drive_tone_crush_delay_chain.sv
sv/adtc_checker.sv
tb/tb_audio_drive_tone_crush_delay_chain.sv
